[design/byte_budget_lru_tag_cache_core_assert.svh]
// Assertion macros for the sprite tag store.
`ifndef BYTE_BUDGET_LRU_TAG_CACHE_CORE_ASSERT_SVH
`define BYTE_BUDGET_LRU_TAG_CACHE_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define BBC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define BBC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define BBC_ASSERT(label, clk, rst, prop, msg)
`define BBC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

[design/bblru_pkg.sv]
// ---------------------------------------------------------------------------
// bblru_pkg
// Shared types and constants of the sprite tag store.
// ---------------------------------------------------------------------------
`default_nettype none
package bblru_pkg;
   localparam logic [1:0] ACT_LOOKUP = 2'd0;
   localparam logic [1:0] ACT_TRIM   = 2'd1;
   localparam logic [1:0] ACT_CLEAR  = 2'd2;
   localparam logic [1:0] OUT_HIT    = 2'd0;
   localparam logic [1:0] OUT_INSERT = 2'd1;
   localparam logic [1:0] OUT_REJECT = 2'd2;
   localparam logic [1:0] OUT_DONE   = 2'd3;
   localparam int PAD_ADD = 15;

   typedef struct packed {
      logic [63:0] key;
      logic [63:0] hash;
      logic [31:0] addr;
      logic [7:0]  tidx;
      logic        opq;
      logic [9:0]  w;
      logic [9:0]  h;
   } tag_type;

   typedef struct packed {
      logic        valid;
      tag_type     tag;
      logic [21:0] size;
      logic [31:0] stamp;
   } entry_type;

   // Command from the controller to every cell.
   typedef struct packed {
      logic        clear;
      logic        touch;   // refresh stamp of a matching cell
      logic        drop;    // drop cell at drop_idx
      logic        fill;    // write cell at fill_idx
      logic [7:0]  drop_idx;
      logic [7:0]  fill_idx;
      logic [31:0] stamp;
      tag_type     tag;
      logic [21:0] size;
   } cmd_type;

   // Result streamed along the chain.
   typedef struct packed {
      logic        hit;
      logic [7:0]  hit_idx;
      logic [21:0] hit_size;
      logic        oldest_ok;
      logic [7:0]  oldest_idx;
      logic [31:0] oldest_stamp;
      logic [21:0] oldest_size;
      logic        free_ok;
      logic [7:0]  free_idx;
      logic [8:0]  valid_cnt;
   } scan_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_DECIDE, ST_EVICT, ST_RESP
   } state_type;
endpackage
`default_nettype wire

[design/bblru_if.sv]
// ---------------------------------------------------------------------------
// bblru_if
// Valid/ready channel carrying one payload.
// ---------------------------------------------------------------------------
`default_nettype none
interface bblru_if #(parameter int WIDTH = 8) ();
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

[design/bblru_cell.sv]
// ---------------------------------------------------------------------------
// bblru_cell
// One slot of the tag store; folds its entry into the scan record.
// ---------------------------------------------------------------------------
`default_nettype none
module bblru_cell #(parameter logic [7:0] INDEX = 8'd0) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire bblru_pkg::cmd_type  cmd,
   input  wire bblru_pkg::tag_type  probe,
   input  wire bblru_pkg::scan_type scan_i,
   output bblru_pkg::scan_type      scan_o
);
   bblru_pkg::entry_type ent_ff;
   logic                 valid_in;
   logic                 match;

   assign match = ent_ff.valid && ent_ff.tag.key == probe.key &&
                  ent_ff.tag.hash == probe.hash && ent_ff.tag.tidx == probe.tidx &&
                  ent_ff.tag.opq == probe.opq && ent_ff.tag.w == probe.w &&
                  ent_ff.tag.h == probe.h &&
                  (probe.hash != 64'd0 || ent_ff.tag.addr == probe.addr);

   always_comb begin
      valid_in = ent_ff.valid;
      if (cmd.clear || (cmd.drop && cmd.drop_idx == INDEX)) valid_in = 1'b0;
      if (cmd.fill && cmd.fill_idx == INDEX) valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_ff.valid <= 1'b0;
      end else begin
         ent_ff.valid <= valid_in;
      end
      if (cmd.fill && cmd.fill_idx == INDEX) begin
         ent_ff.tag   <= cmd.tag;
         ent_ff.size  <= cmd.size;
         ent_ff.stamp <= cmd.stamp;
      end else if (cmd.touch && match) begin
         ent_ff.stamp <= cmd.stamp;
      end
   end

   // Fold: first match, lowest free, oldest with lowest index on ties.
   always_comb begin
      scan_o = scan_i;
      if (ent_ff.valid) begin
         scan_o.valid_cnt = scan_i.valid_cnt + 9'd1;
         if (match && !scan_i.hit) begin
            scan_o.hit      = 1'b1;
            scan_o.hit_idx  = INDEX;
            scan_o.hit_size = ent_ff.size;
         end
         if (!scan_i.oldest_ok || ent_ff.stamp < scan_i.oldest_stamp) begin
            scan_o.oldest_ok    = 1'b1;
            scan_o.oldest_idx   = INDEX;
            scan_o.oldest_stamp = ent_ff.stamp;
            scan_o.oldest_size  = ent_ff.size;
         end
      end else if (!scan_i.free_ok) begin
         scan_o.free_ok  = 1'b1;
         scan_o.free_idx = INDEX;
      end
   end
endmodule
`default_nettype wire

[design/bblru_chain.sv]
// ---------------------------------------------------------------------------
// bblru_chain
// Row of cells with a register after every cell.
// ---------------------------------------------------------------------------
`default_nettype none
module bblru_chain #(parameter int ENTRY_COUNT = 16) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire bblru_pkg::cmd_type  cmd,
   input  wire bblru_pkg::tag_type  probe,
   output bblru_pkg::scan_type      scan_out
);
   bblru_pkg::scan_type link [ENTRY_COUNT+1];
   bblru_pkg::scan_type pipe_ff [ENTRY_COUNT];

   assign link[0] = '0;
   for (genvar i = 0; i < ENTRY_COUNT; i++) begin : g_cell
      bblru_pkg::scan_type s_o;
      bblru_cell #(.INDEX(8'(i))) u_cell (
         .clock(clock), .reset(reset), .cmd(cmd), .probe(probe),
         .scan_i(link[i]), .scan_o(s_o));
      // register the hand-off to the next cell
      always_ff @(posedge clock) begin
         pipe_ff[i] <= s_o;
      end
      assign link[i+1] = pipe_ff[i];
   end
   assign scan_out = link[ENTRY_COUNT];
endmodule
`default_nettype wire

[design/byte_budget_lru_tag_cache_core.sv]
// ---------------------------------------------------------------------------
// byte_budget_lru_tag_cache_core
// Byte-budgeted LRU tag store for cached sprite images.
// ---------------------------------------------------------------------------
// Each request is served alone. Each slot lives in a cell of a chain; a scan
// record walks the chain one cell per cycle through ENTRY_COUNT registered
// hand-offs, and one pass yields the first match, lowest free slot, oldest
// slot and the valid count. A hit, reject, clean insert, a clear, or a trim
// with nothing left to drop answers after one pass; every eviction adds one
// more pass. A budget write is taken at idle and trims in the same way,
// holding off requests for one pass plus one pass per eviction. The response
// sits in an output register; the next request is taken only once that
// response leaves, at the latest in the same cycle.
`default_nettype none
`include "byte_budget_lru_tag_cache_core_assert.svh"
module byte_budget_lru_tag_cache_core #(
   parameter int ENTRY_COUNT = 16,
   parameter int MAX_SIDE    = 1023
) (
   input  wire logic clock,
   input  wire logic reset,
   bblru_if.sink     req,
   bblru_if.source   rsp,
   bblru_if.sink     csr
);
   localparam int CW = $clog2(ENTRY_COUNT + 1);

   bblru_pkg::state_type state_ff, state_in;
   bblru_pkg::cmd_type   cmd;
   bblru_pkg::scan_type  scan;
   bblru_pkg::tag_type   tag_ff;

   logic [1:0]  action_ff;
   logic [15:0] pitch_ff;
   logic [31:0] budget_ff, used_ff, used_in, age_ff, age_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [4:0]  evict_ff, evict_in;
   logic        trim_ff, trim_in;       // scanning for budget write
   logic [10:0] pad;
   logic [21:0] size_ff;
   logic [21:0] prod_ff;
   logic        rej;
   logic        fits;
   logic        rsp_valid_ff;
   logic [1:0]  o_outcome_ff, o_outcome_in;
   logic [3:0]  o_slot_ff, o_slot_in;
   logic [20:0] o_bytes_ff, o_bytes_in;
   logic        take_req, take_csr, load_rsp;
   logic [31:0] used_less;

   // Payload unpack.
   logic [1:0]  r_action;
   logic [63:0] r_key, r_hash;
   logic [31:0] r_addr;
   logic [7:0]  r_tidx;
   logic        r_opq;
   logic [9:0]  r_w, r_h;
   logic [15:0] r_pitch;
   assign {r_action, r_key, r_hash, r_addr, r_tidx, r_opq, r_w, r_h, r_pitch} = req.payload;

   assign take_req = req.valid && req.ready;
   assign take_csr = csr.valid && csr.ready;
   assign req.ready = state_ff == bblru_pkg::ST_IDLE && !csr.valid &&
                      (!rsp_valid_ff || rsp.ready);
   assign csr.ready = state_ff == bblru_pkg::ST_IDLE && !trim_ff;

   bblru_chain #(.ENTRY_COUNT(ENTRY_COUNT)) u_chain (
      .clock(clock), .reset(reset), .cmd(cmd), .probe(tag_ff), .scan_out(scan));

   // Size: padded width times height, plus width times height when hashed.
   assign pad = (11'(tag_ff.w) + 11'(bblru_pkg::PAD_ADD)) & ~11'(bblru_pkg::PAD_ADD);
   always_ff @(posedge clock) begin
      prod_ff <= 22'(pad) * 22'(tag_ff.h);
      size_ff <= prod_ff + ((tag_ff.hash != 64'd0) ? 22'(tag_ff.w) * 22'(tag_ff.h) : 22'd0);
   end

   assign rej = budget_ff == 32'd0 || tag_ff.w == 10'd0 || tag_ff.h == 10'd0 ||
                32'(tag_ff.w) > 32'(MAX_SIDE) || 32'(tag_ff.h) > 32'(MAX_SIDE) ||
                ((pitch_ff != 16'd0) && pitch_ff < 16'(tag_ff.w)) ||
                32'(size_ff) > budget_ff;
   // trims need no extra room
   assign fits = 33'(used_ff) + ((action_ff == bblru_pkg::ACT_LOOKUP && !trim_ff) ?
                 33'(size_ff) : 33'd0) <= 33'(budget_ff);
   assign used_less = used_ff - 32'(scan.oldest_size);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bblru_pkg::ST_IDLE: begin
            if (take_req || trim_in) state_in = bblru_pkg::ST_SCAN;
         end
         bblru_pkg::ST_SCAN: begin
            if (cnt_ff == CW'(ENTRY_COUNT)) state_in = bblru_pkg::ST_DECIDE;
         end
         bblru_pkg::ST_DECIDE: state_in = bblru_pkg::ST_RESP;
         bblru_pkg::ST_EVICT: state_in = bblru_pkg::ST_SCAN;
         bblru_pkg::ST_RESP: state_in = bblru_pkg::ST_IDLE;
         default: state_in = bblru_pkg::ST_IDLE;
      endcase
      // decide may loop back to evict
      if (state_ff == bblru_pkg::ST_DECIDE && cmd.drop) state_in = bblru_pkg::ST_EVICT;
      if (state_ff == bblru_pkg::ST_DECIDE && trim_ff && !cmd.drop)
         state_in = bblru_pkg::ST_IDLE;
   end

   always_comb begin
      cmd          = '0;
      cmd.tag      = tag_ff;
      cmd.size     = size_ff;
      cmd.stamp    = age_ff + 32'd1;
      used_in      = used_ff;
      age_in       = age_ff;
      evict_in     = evict_ff;
      trim_in      = trim_ff;
      load_rsp     = 1'b0;
      o_outcome_in = bblru_pkg::OUT_DONE;
      o_slot_in    = 4'd0;
      o_bytes_in   = 21'd0;
      cnt_in       = (state_ff == bblru_pkg::ST_SCAN) ? cnt_ff + CW'(1) : '0;
      if (take_csr) trim_in = 1'b1;
      if (state_ff == bblru_pkg::ST_DECIDE) begin
         if (trim_ff || action_ff == bblru_pkg::ACT_TRIM) begin
            if (!fits && scan.oldest_ok) begin
               cmd.drop = 1'b1; cmd.drop_idx = scan.oldest_idx;
               used_in = used_less; evict_in = evict_ff + 5'd1;
            end else if (trim_ff) begin
               trim_in = 1'b0;
            end else begin
               load_rsp = 1'b1;
            end
         end else if (action_ff == bblru_pkg::ACT_CLEAR) begin
            cmd.clear = 1'b1; used_in = '0; age_in = '0;
            evict_in = 5'(scan.valid_cnt); load_rsp = 1'b1;
         end else if (action_ff == bblru_pkg::ACT_LOOKUP) begin
            if (scan.hit && evict_ff == 5'd0) begin
               cmd.touch = 1'b1; age_in = age_ff + 32'd1;
               o_outcome_in = bblru_pkg::OUT_HIT;
               o_slot_in = 4'(scan.hit_idx); o_bytes_in = 21'(scan.hit_size);
               load_rsp = 1'b1;
            end else if (rej && evict_ff == 5'd0) begin
               o_outcome_in = bblru_pkg::OUT_REJECT; load_rsp = 1'b1;
            end else if ((!fits && scan.oldest_ok) || !scan.free_ok) begin
               cmd.drop = 1'b1; cmd.drop_idx = scan.oldest_idx;
               used_in = used_less; evict_in = evict_ff + 5'd1;
            end else begin
               cmd.fill = 1'b1; cmd.fill_idx = scan.free_idx;
               age_in = age_ff + 32'd1; used_in = used_ff + 32'(size_ff);
               o_outcome_in = bblru_pkg::OUT_INSERT;
               o_slot_in = 4'(scan.free_idx); o_bytes_in = 21'(size_ff);
               load_rsp = 1'b1;
            end
         end else begin
            load_rsp = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bblru_pkg::ST_IDLE;
         budget_ff <= '0; used_ff <= '0; age_ff <= '0;
         cnt_ff <= '0; evict_ff <= '0; trim_ff <= 1'b0; rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff <= used_in; age_ff <= age_in; cnt_ff <= cnt_in;
         trim_ff <= trim_in;
         if (take_csr) budget_ff <= csr.payload;
         if (take_req || (state_ff == bblru_pkg::ST_IDLE && trim_in)) evict_ff <= '0;
         else evict_ff <= evict_in;
         if (load_rsp) rsp_valid_ff <= 1'b1;
         else if (rsp.ready) rsp_valid_ff <= 1'b0;
      end
      if (take_req) begin
         action_ff <= r_action;
         tag_ff    <= '{key: r_key, hash: r_hash, addr: r_addr, tidx: r_tidx,
                        opq: r_opq, w: r_w, h: r_h};
         pitch_ff  <= r_pitch;
      end
      if (load_rsp) begin
         o_outcome_ff <= o_outcome_in;
         o_slot_ff    <= o_slot_in;
         o_bytes_ff   <= o_bytes_in;
      end
   end

   logic [4:0]  o_evict_ff;
   logic [31:0] o_used_ff;
   logic [10:0] o_pad_ff;
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         o_evict_ff <= evict_in;
         o_used_ff  <= used_in;
         o_pad_ff   <= (action_ff == bblru_pkg::ACT_LOOKUP) ? pad : 11'd0;
      end
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = {o_outcome_ff, o_slot_ff, o_evict_ff, o_used_ff, o_bytes_ff, o_pad_ff};

   `BBC_ASSERT(a_one_op, clock, reset, !(cmd.fill && cmd.drop), "fill and drop together")
   `BBC_ASSERT(a_used, clock, reset, state_ff != bblru_pkg::ST_IDLE || used_ff <= budget_ff, "used over budget")
   `BBC_ASSERT_NEXT(a_rsp, clock, reset, load_rsp, rsp_valid_ff, "response lost")
   `BBC_ASSERT(a_idle_req, clock, reset, !take_req || !rsp_valid_ff || rsp.ready, "request over full output")
endmodule
`default_nettype wire

[tb/tb_bblru_scoreboard.sv]
// ---------------------------------------------------------------------------
// Sprite tag store scoreboard
// Tracks the tag store contents, budget and age counter, predicts the
// response of each accepted request and compares it with what arrives.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps
package tb_bblru_sb_pkg;
   localparam int SLOTS    = 16;
   localparam int SIDE_MAX = 1023;
   // action code with no function
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]  action;
      logic [63:0] key;
      logic [63:0] hash;
      logic [31:0] addr;
      logic [7:0]  tidx;
      logic        opq;
      logic [9:0]  w;
      logic [9:0]  h;
      logic [15:0] pitch;
   } sprite_req_type;

   typedef struct packed {
      logic [1:0]  outcome;
      logic [3:0]  slot;
      logic [4:0]  evicted;
      logic [31:0] used;
      logic [20:0] ebytes;
      logic [10:0] pad;
   } sprite_rsp_type;

   class tag_store_scoreboard;
      bit [31:0]          budget;
      bit                 live[SLOTS];
      bblru_pkg::tag_type tags[SLOTS];
      bit [31:0]          sizes[SLOTS];
      bit [31:0]          stamps[SLOTS];
      bit [31:0]          age;
      bit [31:0]          used;
      sprite_rsp_type     pending[$];
      int                 mismatches;

      function new();
         budget = 0;
         age = 0;
         used = 0;
         mismatches = 0;
         foreach (live[i]) live[i] = 0;
      endfunction

      function int oldest();
         int best;
         best = -1;
         for (int i = 0; i < SLOTS; i++)
            if (live[i] && (best < 0 || stamps[i] < stamps[best])) best = i;
         return best;
      endfunction

      // evict oldest entries until extra more bytes fit the budget
      function int make_room(bit [31:0] extra);
         int n;
         int s;
         n = 0;
         forever begin
            if ({32'd0, used} + {32'd0, extra} <= {32'd0, budget}) break;
            s = oldest();
            if (s < 0) break;
            live[s] = 0;
            used -= sizes[s];
            n++;
         end
         return n;
      endfunction

      function void note_budget(bit [31:0] value);
         int n;
         budget = value;
         n = make_room(0);
      endfunction

      function void note_request(sprite_req_type r);
         sprite_rsp_type     e;
         int                 hit;
         int                 fs;
         bit [31:0]          pitch;
         bit [31:0]          size;
         bit [31:0]          pad;
         int                 ev;
         bblru_pkg::tag_type t;
         e = '0;
         e.outcome = bblru_pkg::OUT_DONE;
         ev = 0;
         t = '{key: r.key, hash: r.hash, addr: r.addr, tidx: r.tidx, opq: r.opq,
               w: r.w, h: r.h};
         if (r.action == bblru_pkg::ACT_LOOKUP) begin
            pad = (32'(r.w) + 32'(bblru_pkg::PAD_ADD)) & ~32'd15;
            e.pad = pad[10:0];
            hit = -1;
            for (int i = 0; i < SLOTS; i++) begin
               if (live[i] && tags[i].key == r.key && tags[i].hash == r.hash &&
                   tags[i].tidx == r.tidx && tags[i].opq == r.opq &&
                   tags[i].w == r.w && tags[i].h == r.h &&
                   (r.hash != 0 || tags[i].addr == r.addr)) begin
                  hit = i;
                  break;
               end
            end
            if (hit >= 0) begin
               age++;
               stamps[hit] = age;
               e.outcome = bblru_pkg::OUT_HIT;
               e.slot = hit[3:0];
               e.ebytes = sizes[hit][20:0];
            end else begin
               pitch = (r.pitch != 0) ? 32'(r.pitch) : 32'(r.w);
               size = pad * r.h + ((r.hash != 0) ? 32'(r.w) * r.h : 0);
               if (budget == 0 || r.w == 0 || r.h == 0 || r.w > SIDE_MAX ||
                   r.h > SIDE_MAX || pitch < r.w || size > budget) begin
                  e.outcome = bblru_pkg::OUT_REJECT;
               end else begin
                  ev = make_room(size);
                  fs = -1;
                  for (int i = 0; i < SLOTS; i++)
                     if (!live[i]) begin
                        fs = i;
                        break;
                     end
                  if (fs < 0) begin
                     fs = oldest();
                     live[fs] = 0;
                     used -= sizes[fs];
                     ev++;
                  end
                  live[fs] = 1;
                  tags[fs] = t;
                  sizes[fs] = size;
                  age++;
                  stamps[fs] = age;
                  used += size;
                  e.outcome = bblru_pkg::OUT_INSERT;
                  e.slot = fs[3:0];
                  e.ebytes = size[20:0];
               end
            end
         end else if (r.action == bblru_pkg::ACT_TRIM) begin
            ev = make_room(0);
         end else if (r.action == bblru_pkg::ACT_CLEAR) begin
            for (int i = 0; i < SLOTS; i++) begin
               if (live[i]) ev++;
               live[i] = 0;
            end
            used = 0;
            age = 0;
         end
         e.evicted = ev[4:0];
         e.used = used;
         pending = {pending, e};
      endfunction

      function void check_response(sprite_rsp_type got);
         sprite_rsp_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", got);
            return;
         end
         e = pending.pop_front();
         if (got !== e) begin
            mismatches++;
            if (mismatches <= 10)
               $display("response mismatch: expected %p, actual %p", e, got);
         end
      endfunction
   endclass
endpackage

[tb/tb_byte_budget_lru_tag_cache_core.sv]
// ---------------------------------------------------------------------------
// Sprite tag store testbench
// Drives lookup, trim and clear requests with random idling on both
// channels, changes the byte budget between phases and checks every
// response against a scoreboard prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps
module tb_byte_budget_lru_tag_cache_core;
   localparam int REQ_W = $bits(tb_bblru_sb_pkg::sprite_req_type);
   localparam int RSP_W = $bits(tb_bblru_sb_pkg::sprite_rsp_type);
   localparam int CYCLE_LIMIT = 3000000;
   localparam int RANDOM_ITEMS = 1150;

   logic clock = 0;
   logic reset = 1;
   int   cycles = 0;
   bit   calm = 0;    // no idling on either side while set

   bblru_if #(.WIDTH(REQ_W)) req_ch ();
   bblru_if #(.WIDTH(RSP_W)) rsp_ch ();
   bblru_if #(.WIDTH(32))    csr_ch ();

   byte_budget_lru_tag_cache_core uut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source),
      .csr   (csr_ch.sink)
   );

   tb_bblru_sb_pkg::tag_store_scoreboard store = new();

   // pool of sprites reused so that lookups hit
   tb_bblru_sb_pkg::sprite_req_type pool[24];

   always #1 clock = ~clock;

   // Abort a hung run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("byte_budget_lru_tag_cache_core test failed");
         $finish;
      end
   end

   // Response side: stall at random, check every accepted response.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         store.check_response(tb_bblru_sb_pkg::sprite_rsp_type'(rsp_ch.payload));
      rsp_ch.ready <= !reset && (calm || ($urandom_range(99) >= 27));
   end

   // Send one request; valid stays high so back-to-back requests need no dip.
   task automatic send_request(tb_bblru_sb_pkg::sprite_req_type r);
      while (!calm && $urandom_range(99) < 27) begin
         req_ch.valid <= 0;
         @(posedge clock);
      end
      req_ch.valid <= 1;
      req_ch.payload <= r;
      do @(posedge clock); while (!req_ch.ready);
      store.note_request(r);
   endtask

   // Write the budget once every response is back; the block is idle then.
   task automatic write_budget(logic [31:0] value);
      req_ch.valid <= 0;
      while (store.pending.size() != 0) @(posedge clock);
      csr_ch.valid <= 1;
      csr_ch.payload <= value;
      do @(posedge clock); while (!csr_ch.ready);
      store.note_budget(value);
      csr_ch.valid <= 0;
   endtask

   function automatic tb_bblru_sb_pkg::sprite_req_type random_sprite();
      tb_bblru_sb_pkg::sprite_req_type r;
      r.action = bblru_pkg::ACT_LOOKUP;
      r.key = {$urandom, $urandom};
      r.hash = ($urandom_range(3) == 0) ? 64'd0 : {$urandom, $urandom};
      r.addr = $urandom;
      r.tidx = 8'($urandom);
      r.opq = 1'($urandom);
      // mostly small sprites, a few huge ones
      if ($urandom_range(19) == 0) begin
         r.w = 10'($urandom_range(1023, 512));
         r.h = 10'($urandom_range(1023, 256));
      end else begin
         r.w = 10'($urandom_range(64, 1));
         r.h = 10'($urandom_range(48, 1));
      end
      r.pitch = ($urandom_range(1) == 0) ? 16'd0 : 16'($urandom_range(65535, 1024));
      return r;
   endfunction

   function automatic tb_bblru_sb_pkg::sprite_req_type op_only(logic [1:0] act);
      tb_bblru_sb_pkg::sprite_req_type r;
      r = random_sprite();
      r.action = act;
      return r;
   endfunction

   function automatic tb_bblru_sb_pkg::sprite_req_type random_request();
      tb_bblru_sb_pkg::sprite_req_type r;
      int                              pick;
      pick = $urandom_range(99);
      if (pick < 55) begin
         r = pool[$urandom_range(23)];
      end else if (pick < 80) begin
         r = random_sprite();
         if ($urandom_range(3) == 0) pool[$urandom_range(23)] = r;
      end else if (pick < 86) begin
         // malformed: zero side or short pitch
         r = random_sprite();
         case ($urandom_range(2))
            0: r.w = 10'd0;
            1: r.h = 10'd0;
            default: begin
               r.w = 10'($urandom_range(1023, 2));
               r.pitch = 16'($urandom_range(32'(r.w) - 1, 1));
            end
         endcase
      end else if (pick < 88) begin
         // near miss on a pooled sprite
         r = pool[$urandom_range(23)];
         r.addr ^= 32'(1) << $urandom_range(31);
      end else if (pick < 94) begin
         r = op_only(bblru_pkg::ACT_TRIM);
      end else if (pick < 97) begin
         r = op_only(bblru_pkg::ACT_CLEAR);
      end else begin
         r = op_only(tb_bblru_sb_pkg::ACT_UNUSED);
      end
      return r;
   endfunction

   initial begin
      tb_bblru_sb_pkg::sprite_req_type r;
      logic [31:0]                     budgets[6];
      int                              waited;
      budgets = '{32'd6000, 32'd40000, 32'd400000, 32'hFFFFFFFF, 32'd2500000, 32'd1};

      req_ch.valid = 0;
      req_ch.payload = '0;
      csr_ch.valid = 0;
      csr_ch.payload = '0;
      foreach (pool[i]) pool[i] = random_sprite();
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: budget zero rejects everything.
      r = pool[0];
      send_request(r);
      write_budget(32'd0);
      send_request(r);
      write_budget(32'hFFFFFFFF);

      // Largest sprite with hash, then hit it.
      r = random_sprite();
      r.w = 10'd1023;
      r.h = 10'd1023;
      r.hash = 64'hFFFF_FFFF_FFFF_FFFF;
      r.key = 64'hFFFF_FFFF_FFFF_FFFF;
      r.pitch = 16'hFFFF;
      send_request(r);
      send_request(r);
      // Zero hash matches by address; a different address misses.
      r = random_sprite();
      r.hash = 64'd0;
      r.key = 64'd0;
      r.addr = 32'd0;
      r.pitch = 16'd0;
      send_request(r);
      send_request(r);
      r.addr = 32'hFFFFFFFF;
      send_request(r);
      // Zero width, zero height, pitch below width.
      r.w = 10'd0;
      send_request(r);
      r.w = 10'd16;
      r.h = 10'd0;
      send_request(r);
      r.h = 10'd5;
      r.pitch = 16'd15;
      send_request(r);
      // Fill past the table depth so a full table evicts the oldest.
      for (int i = 0; i < 17; i++) send_request(random_sprite());
      send_request(op_only(bblru_pkg::ACT_TRIM));
      send_request(op_only(tb_bblru_sb_pkg::ACT_UNUSED));
      send_request(op_only(bblru_pkg::ACT_CLEAR));

      // Random phases, each with its own budget; shrinking it trims at once.
      for (int ph = 0; ph < 6; ph++) begin
         write_budget(budgets[ph]);
         foreach (pool[i]) if ($urandom_range(1) == 0) pool[i] = random_sprite();
         calm = (ph == 2);
         for (int n = 0; n < RANDOM_ITEMS / 6; n++) send_request(random_request());
         calm = 0;
      end
      write_budget(32'd0);
      send_request(op_only(bblru_pkg::ACT_TRIM));
      req_ch.valid <= 0;

      // Drain, then let the last response settle.
      waited = 0;
      while (store.pending.size() != 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      repeat (400) @(posedge clock);
      if (store.mismatches == 0 && store.pending.size() == 0)
         $display("byte_budget_lru_tag_cache_core test passed");
      else
         $display("byte_budget_lru_tag_cache_core test failed");
      $finish;
   end
endmodule
